// ===== rtl/bai_pkg.sv =====
`timescale 1ns / 1ps

package bai_pkg;

	// Vector geometry.
	localparam int MAX_BITS   = 4096;
	localparam int WORD_WIDTH = 32;
	localparam int WORDS_MAX  = (MAX_BITS + WORD_WIDTH - 1) / WORD_WIDTH;

	// Derived widths.
	localparam int LIMIT_W = $clog2(MAX_BITS + 1);
	localparam int INDEX_W = $clog2(MAX_BITS);
	localparam int BIT_W   = $clog2(WORD_WIDTH);
	localparam int WPOS_W  = $clog2(WORDS_MAX + 1);
	localparam int BASE_W  = WPOS_W + BIT_W;
	localparam int EXT_W   = ((BASE_W > LIMIT_W) ? BASE_W : LIMIT_W) + 1;

	// One input item: a word of the vector and the end-of-run flag.
	typedef struct packed {
		logic [31:0] data_word;
		logic        last_word;
	} in_item_t;

	// One result item: either an index or the closing count.
	typedef struct packed {
		logic [11:0] active_index;
		logic        index_valid;
		logic [12:0] total_set;
		logic        run_done;
	} out_item_t;

	// Result of the shared lowest-set-bit unit.
	typedef struct packed {
		logic                  found;
		logic [BIT_W-1:0]      bit_idx;
		logic [WORD_WIDTH-1:0] rest;
	} scan_res_t;

endpackage

// ===== rtl/bai_lowbit.sv =====
`timescale 1ns / 1ps

// Finds the lowest set bit of a word and returns the word with that bit cleared.
module bai_lowbit import bai_pkg::*; (
	input  logic [WORD_WIDTH-1:0] word,
	output scan_res_t             res
);

	logic [WORD_WIDTH-1:0] onehot;
	logic [BIT_W-1:0]      idx;

	// Isolate the lowest set bit.
	assign onehot = word & (~word + WORD_WIDTH'(1));

	// Encode the one-hot position; each index bit is an OR over its positions.
	always_comb begin
		idx = '0;
		for (int k = 0; k < BIT_W; k++) begin
			for (int b = 0; b < WORD_WIDTH; b++) begin
				if (((b >> k) & 1) == 1) begin
					idx[k] = idx[k] | onehot[b];
				end
			end
		end
	end

	assign res.found   = |word;
	assign res.bit_idx = idx;
	assign res.rest    = word & (word - WORD_WIDTH'(1));

endmodule

// ===== rtl/bitmap_to_active_index_list_unit.sv =====
`timescale 1ns / 1ps

// Bitmap to active index list. Words of a bit vector arrive least significant
// bit first; every set bit below the active_bits limit (clamped to 4096) leaves
// as one item carrying its position, in ascending order, and the word flagged
// last is followed by a closing item with the count of those bits. A word is
// accepted in the idle state; the scan state emits one item per kept set bit
// and retires the word once none remain, and after a last word it goes on to the
// closing state. The block takes no new word meanwhile. The rate is set by the
// shared lowest-set-bit unit, which yields one position per cycle, and by the
// single output register, which stalls the scan while its item is not taken.
// Configuration writes are always taken and apply from the next word.
module bitmap_to_active_index_list_unit import bai_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [LIMIT_W-1:0]  cfg_data,
	input  logic                in_valid,
	output logic                in_ready,
	input  in_item_t            in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output out_item_t           out_data
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_CLOSE
	} state_t;

	state_t                state_q;
	logic [LIMIT_W-1:0]    active_q;
	logic [WPOS_W-1:0]     wpos_q;
	logic [WPOS_W-1:0]     base_q;
	logic [LIMIT_W-1:0]    count_q;
	logic [WORD_WIDTH-1:0] word_q;
	logic                  last_q;
	logic                  out_valid_q;
	out_item_t             out_data_q;

	logic [LIMIT_W-1:0]    limit;
	logic [EXT_W-1:0]      base_ext;
	logic [EXT_W-1:0]      limit_ext;
	logic [EXT_W-1:0]      rem;
	logic                  in_range;
	logic [WORD_WIDTH-1:0] keep_mask;
	logic                  slot_free;
	logic                  emit;
	scan_res_t             scan;

	assign cfg_ready = 1'b1;
	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;
	assign slot_free = !out_valid_q || out_ready;

	// A new item enters the output register this cycle.
	assign emit = slot_free && (((state_q == ST_SCAN) && scan.found) || (state_q == ST_CLOSE));

	// Clamp the limit and build the mask of positions of this word below it.
	assign limit     = (active_q > LIMIT_W'(MAX_BITS)) ? LIMIT_W'(MAX_BITS) : active_q;
	assign in_range  = (wpos_q < WPOS_W'(WORDS_MAX));
	assign base_ext  = EXT_W'({wpos_q, {BIT_W{1'b0}}});
	assign limit_ext = EXT_W'(limit);
	assign rem       = limit_ext - base_ext;

	always_comb begin
		if (!in_range || (limit_ext <= base_ext)) begin
			keep_mask = '0;
		end else if (rem >= EXT_W'(WORD_WIDTH)) begin
			keep_mask = '1;
		end else begin
			keep_mask = ~({WORD_WIDTH{1'b1}} << rem[BIT_W-1:0]);
		end
	end

	// Shared unit: one kept position per cycle while the output register is free.
	bai_lowbit u_lowbit (
		.word (word_q),
		.res  (scan)
	);

	// Sequencer with the output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			active_q    <= LIMIT_W'(MAX_BITS);
			wpos_q      <= '0;
			base_q      <= '0;
			count_q     <= '0;
			word_q      <= '0;
			last_q      <= 1'b0;
			out_valid_q <= 1'b0;
			out_data_q  <= '0;
		end else begin
			if (cfg_valid) begin
				active_q <= cfg_data;
			end
			// The output item stays until taken; a new one may replace it at once.
			out_valid_q <= emit || (out_valid_q && !out_ready);
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						word_q  <= in_data.data_word & keep_mask;
						last_q  <= in_data.last_word;
						base_q  <= wpos_q;
						if (in_range) begin
							wpos_q <= wpos_q + WPOS_W'(1);
						end
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (scan.found) begin
						if (slot_free) begin
							out_data_q.active_index <= INDEX_W'({base_q, scan.bit_idx});
							out_data_q.index_valid  <= 1'b1;
							out_data_q.total_set    <= '0;
							out_data_q.run_done     <= 1'b0;
							word_q                  <= scan.rest;
							count_q                 <= count_q + LIMIT_W'(1);
						end
					end else if (last_q) begin
						state_q <= ST_CLOSE;
					end else begin
						state_q <= ST_IDLE;
					end
				end
				ST_CLOSE: begin
					if (slot_free) begin
						out_data_q.active_index <= '0;
						out_data_q.index_valid  <= 1'b0;
						out_data_q.total_set    <= count_q;
						out_data_q.run_done     <= 1'b1;
						count_q                 <= '0;
						wpos_q                  <= '0;
						state_q                 <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// An accepted word always starts a scan.
	a_accept_scan: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> state_q == ST_SCAN)
		else $error("accepted word did not start a scan");

	// Index items and closing items never mix their fields.
	a_item_kind: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_data.index_valid != out_data.run_done))
		else $error("result item is neither index nor closing");

	// The word position never passes one beyond the last word.
	a_wpos_bound: assert property (@(posedge clk) disable iff (!arst_n)
		wpos_q <= WPOS_W'(WORDS_MAX))
		else $error("word position out of range");

	// The count cannot exceed the vector capacity.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= LIMIT_W'(MAX_BITS))
		else $error("set bit count out of range");

endmodule

// ===== tb/tb_bitmap_to_active_index_list_unit.sv =====
`timescale 1ns / 1ps

module tb_bitmap_to_active_index_list_unit;
	import bai_pkg::*;

	localparam int RESET_CYCLES = 9;
	localparam int CYCLE_LIMIT  = 20_000_000;
	localparam int DRAIN_CYCLES = 40;
	localparam int RANDOM_ITEMS = 450;
	localparam int MAX_REPORTS  = 10;

	// Predicts the index list of each run and checks the items that leave the block.
	class active_index_scoreboard;
		logic [LIMIT_W-1:0] active_bits;
		int unsigned        word_pos;
		logic [12:0]        run_count;
		out_item_t          expected_q[$];
		int                 mismatches;
		int                 checked;

		function new();
			active_bits = 13'd4096;
			word_pos    = 0;
			run_count   = '0;
			mismatches  = 0;
			checked     = 0;
		endfunction

		function int pending();
			return expected_q.size();
		endfunction

		// Works out the items that one accepted word causes.
		function void note_word(in_item_t word);
			int unsigned lim;
			int unsigned pos;
			int unsigned kept;
			out_item_t   res;
			lim  = (active_bits > MAX_BITS) ? MAX_BITS : active_bits;
			kept = 0;
			if (word_pos < WORDS_MAX) begin
				for (int b = 0; b < WORD_WIDTH; b++) begin
					pos = word_pos * WORD_WIDTH + b;
					if (pos >= lim)
						break;
					if (word.data_word[b]) begin
						res              = '0;
						res.active_index = pos[11:0];
						res.index_valid  = 1'b1;
						expected_q.push_back(res);
						kept++;
					end
				end
				run_count = run_count + kept[12:0];
				word_pos++;
			end
			// The last word closes the run with its count.
			if (word.last_word) begin
				res           = '0;
				res.total_set = run_count;
				res.run_done  = 1'b1;
				expected_q.push_back(res);
				word_pos  = 0;
				run_count = '0;
			end
		endfunction

		// Compares one result item with the oldest expectation.
		function void check_result(out_item_t got);
			out_item_t want;
			if (expected_q.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("ERROR: unexpected item index=%0d iv=%0d total=%0d done=%0d",
						got.active_index, got.index_valid, got.total_set, got.run_done);
				return;
			end
			want = expected_q.pop_front();
			checked++;
			if (got.active_index !== want.active_index || got.index_valid !== want.index_valid ||
					got.total_set !== want.total_set || got.run_done !== want.run_done) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS) begin
					$write("ERROR: item %0d expected index=%0d iv=%0d total=%0d done=%0d, ",
						checked, want.active_index, want.index_valid, want.total_set,
						want.run_done);
					$display("got index=%0d iv=%0d total=%0d done=%0d",
						got.active_index, got.index_valid, got.total_set, got.run_done);
				end
			end
		endfunction
	endclass

	logic               clk = 1'b0;
	logic               arst_n;
	logic               cfg_valid;
	logic               cfg_ready;
	logic [LIMIT_W-1:0] cfg_data;
	logic               in_valid;
	logic               in_ready;
	in_item_t           in_data;
	logic               out_valid;
	logic               out_ready = 1'b0;
	out_item_t          out_data;

	active_index_scoreboard sb = new();

	int cycles      = 0;
	int words_sent  = 0;
	int runs_sent   = 0;
	int limit_writes = 0;
	int in_idle_pct = 0;
	int stall_pct   = 0;
	int stall_left  = 0;

	bitmap_to_active_index_list_unit DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data (cfg_data),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Gap length: mostly short, now and then long.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 75)
			return $urandom_range(1, 3);
		else if (r < 95)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// Word contents from empty through sparse to full.
	function automatic logic [31:0] rand_word();
		logic [31:0] w;
		case ($urandom_range(0, 9))
			0: w = '0;
			1: w = '1;
			2: w = 32'd1 << $urandom_range(0, 31);
			3, 4: w = $urandom() & $urandom() & $urandom();
			5, 6: w = $urandom();
			7: w = $urandom() | $urandom();
			8: w = (32'd1 << $urandom_range(0, 31)) | (32'd1 << $urandom_range(0, 31));
			default: w = $urandom() & ({32{1'b1}} >> $urandom_range(0, 31));
		endcase
		return w;
	endfunction

	// Cycle count and timeout.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles with %0d items outstanding.", cycles, sb.pending());
			$display("tb_bitmap_to_active_index_list_unit failed");
			$finish;
		end
	end

	// Receiver side: random stalls on out_ready.
	always @(posedge clk) begin
		if (stall_left > 0) begin
			out_ready <= 1'b0;
			stall_left = stall_left - 1;
		end else if ($urandom_range(0, 99) < stall_pct) begin
			out_ready <= 1'b0;
			stall_left = pick_gap() - 1;
		end else begin
			out_ready <= 1'b1;
		end
	end

	// Every accepted result item goes to the checker.
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			sb.check_result(out_data);
	end

	// Sends one word; valid stays high after acceptance until the next call or idle wait.
	task automatic send_word(input logic [31:0] w, input logic last, input int gap);
		in_item_t it;
		it.data_word = w;
		it.last_word = last;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= it;
		do @(posedge clk); while (!in_ready);
		sb.note_word(it);
		words_sent++;
		if (last)
			runs_sent++;
	endtask

	// Lets the block finish all pending work.
	task automatic wait_idle();
		in_valid <= 1'b0;
		while (sb.pending() > 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_active_bits(input logic [LIMIT_W-1:0] value);
		wait_idle();
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		sb.active_bits = value;
		limit_writes++;
	endtask

	// One run of random or fill words, the final one flagged last.
	task automatic send_run(input int words, input logic [31:0] fill, input bit use_fill);
		int gap;
		for (int i = 0; i < words; i++) begin
			gap = ($urandom_range(0, 99) < in_idle_pct) ? pick_gap() : 0;
			send_word(use_fill ? fill : rand_word(), i == words - 1, gap);
		end
	endtask

	initial begin
		int random_words;
		int runs;
		int len;
		int r;
		logic [LIMIT_W-1:0] lim;

		arst_n    <= 1'b0;
		cfg_valid <= 1'b0;
		cfg_data  <= '0;
		in_valid  <= 1'b0;
		in_data   <= '0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: empty run, edge bits, word boundaries, zero and oversized limits.
		send_word(32'h0000_0000, 1'b1, 0);
		send_word(32'hFFFF_FFFF, 1'b0, 0);
		send_word(32'h8000_0001, 1'b0, 0);
		send_word(32'h0000_0000, 1'b1, 0);
		write_active_bits(13'd40);
		send_word(32'hFFFF_FFFF, 1'b0, 0);
		send_word(32'hFFFF_FFFF, 1'b1, 0);
		write_active_bits(13'd0);
		send_word(32'hFFFF_FFFF, 1'b1, 0);
		write_active_bits(13'd8191);
		stall_pct = 30;
		send_word(32'hAAAA_AAAA, 1'b0, 0);
		send_word(32'h5555_5555, 1'b1, 2);
		write_active_bits(13'd1);
		send_word(32'h0000_0001, 1'b1, 0);
		send_word(32'hFFFF_FFFE, 1'b1, 0);
		send_word(32'hFFFF_FFFF, 1'b0, 1);
		send_word(32'hFFFF_FFFF, 1'b1, 0);
		write_active_bits(13'd33);
		send_word(32'hFFFF_FFFF, 1'b0, 0);
		send_word(32'h0000_0003, 1'b1, 0);

		// A full vector at the capacity limit, then a run that overflows the word count.
		random_words = 0;
		write_active_bits(13'd4096);
		stall_pct   = 10;
		in_idle_pct = 10;
		send_run(WORDS_MAX, 32'hFFFF_FFFF, 1'b1);
		write_active_bits(13'd8191);
		send_run(WORDS_MAX + 3, '0, 1'b0);
		random_words += 2 * WORDS_MAX + 3;

		// Random phases: a limit, idle and stall levels, then a few runs.
		while (random_words < RANDOM_ITEMS) begin
			case ($urandom_range(0, 7))
				0: lim = 13'd4096;
				1: lim = LIMIT_W'($urandom_range(1, 64));
				2: lim = LIMIT_W'($urandom_range(1, 4096));
				3: lim = LIMIT_W'(32 * $urandom_range(1, 8));
				4: lim = 13'd0;
				5: lim = LIMIT_W'($urandom_range(4097, 8191));
				6: lim = LIMIT_W'($urandom_range(65, 300));
				default: lim = LIMIT_W'($urandom_range(1, 160));
			endcase
			write_active_bits(lim);
			case ($urandom_range(0, 2))
				0: in_idle_pct = 0;
				1: in_idle_pct = 20;
				default: in_idle_pct = 50;
			endcase
			case ($urandom_range(0, 2))
				0: stall_pct = 0;
				1: stall_pct = 15;
				default: stall_pct = 40;
			endcase
			runs = $urandom_range(2, 6);
			for (int k = 0; k < runs; k++) begin
				r = $urandom_range(0, 99);
				if (r < 70)
					len = $urandom_range(1, 4);
				else if (r < 97)
					len = $urandom_range(5, 12);
				else
					len = $urandom_range(WORDS_MAX + 1, WORDS_MAX + 4);
				send_run(len, '0, 1'b0);
				random_words += len;
			end
		end

		// Drain and report.
		wait_idle();
		if (sb.pending() > 0) begin
			$display("ERROR: %0d expected items never arrived.", sb.pending());
			sb.mismatches += sb.pending();
		end
		$display("Covered %0d words in %0d runs under %0d limit settings.",
			words_sent, runs_sent, limit_writes);
		$display("Checked %0d result items in %0d cycles, %0d mismatches.",
			sb.checked, cycles, sb.mismatches);
		if (sb.mismatches == 0)
			$display("tb_bitmap_to_active_index_list_unit passed");
		else
			$display("tb_bitmap_to_active_index_list_unit failed");
		$finish;
	end

endmodule
